// File: hw/rtl/fia_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and types of the frame interval averager.
package fia_pkg;

    // Field widths fixed by the interface
    localparam int FUNC_W = 2;
    localparam int CAT_W  = 2;
    localparam int TICK_W = 32;
    localparam int CFG_W  = 32;
    localparam int AVG_W  = 40;
    localparam int ACC_W  = 40;
    localparam int FRAC_W = 8;

    // Sizing
    localparam int FRAMES  = 16;
    localparam int CAT_N   = 3;
    localparam int POS_W   = $clog2(FRAMES);
    localparam int CNT_W   = $clog2(FRAMES + 1);
    localparam int SUM_W   = TICK_W + $clog2(FRAMES);
    localparam int DVD_W   = SUM_W + FRAC_W;
    localparam int DSTEP_W = $clog2(DVD_W + 1);
    localparam int RING_N  = CAT_N * FRAMES;
    localparam int RING_AW = $clog2(RING_N);
    localparam int CIDX_W  = (CAT_N > 1) ? $clog2(CAT_N) : 1;

    // Command queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    localparam logic [CFG_W-1:0] CFG_RESET = 32'd16667;

    // Operation codes on s_func
    localparam logic [FUNC_W-1:0] FUNC_START = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_BEGIN = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_MARK  = 2'd2;

    typedef enum logic [2:0] {
        CMD_NONE,   // category out of range: all-zero result
        CMD_START,
        CMD_BEGIN,
        CMD_MARK,
        CMD_QUERY
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [CAT_W-1:0]  cat;
        logic [TICK_W-1:0] now;
    } cmd_word_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_DISPATCH,
        BK_LOAD,
        BK_DIV,
        BK_EMIT
    } bk_state_t;

    typedef struct packed {
        logic div_wait;
        logic emit;
    } bk_status_t;

endpackage

// File: hw/rtl/fia_front.sv
`timescale 1ns / 1ps
// Front end: accepts input words, classifies them and queues commands.
module fia_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [fia_pkg::FUNC_W-1:0]  s_func,
    input  logic [fia_pkg::CAT_W-1:0]   s_category,
    input  logic [fia_pkg::TICK_W-1:0]  s_now_ticks,
    output logic                        q_valid,
    output fia_pkg::cmd_word_t          q_word,
    input  logic                        q_pop
);

    fia_pkg::cmd_word_t             slot_reg [fia_pkg::Q_DEPTH];
    logic [fia_pkg::Q_AW-1:0]       wr_ptr_reg;
    logic [fia_pkg::Q_AW-1:0]       rd_ptr_reg;
    logic [fia_pkg::Q_CW-1:0]       cnt_reg;
    fia_pkg::cmd_word_t             cmd;
    logic                           push;

    always_comb begin
        cmd.cat = s_category;
        cmd.now = s_now_ticks;
        if (32'(s_category) >= fia_pkg::CAT_N) begin
            cmd.kind = fia_pkg::CMD_NONE;
        end else begin
            unique case (s_func)
                fia_pkg::FUNC_START: cmd.kind = fia_pkg::CMD_START;
                fia_pkg::FUNC_BEGIN: cmd.kind = fia_pkg::CMD_BEGIN;
                fia_pkg::FUNC_MARK:  cmd.kind = fia_pkg::CMD_MARK;
                default:             cmd.kind = fia_pkg::CMD_QUERY;
            endcase
        end
    end

    assign s_ready = (cnt_reg != fia_pkg::Q_CW'(fia_pkg::Q_DEPTH));
    assign push    = s_valid && s_ready;
    assign q_valid = (cnt_reg != '0);
    assign q_word  = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == fia_pkg::Q_AW'(fia_pkg::Q_DEPTH - 1))
                              ? '0 : wr_ptr_reg + 1'b1;
            end
            if (q_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == fia_pkg::Q_AW'(fia_pkg::Q_DEPTH - 1))
                              ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !q_pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (!push && q_pop) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= cmd;
        end
    end

endmodule

// File: hw/rtl/fia_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
module fia_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [fia_pkg::DVD_W-1:0]   dividend,
    input  logic [fia_pkg::CNT_W-1:0]   divisor,
    output logic                        busy,
    output logic                        done,
    output logic [fia_pkg::DVD_W-1:0]   quotient
);

    logic [fia_pkg::DVD_W-1:0]   dvd_reg;
    logic [fia_pkg::CNT_W-1:0]   rem_reg;
    logic [fia_pkg::CNT_W-1:0]   dsr_reg;
    logic [fia_pkg::DSTEP_W-1:0] step_reg;
    logic                        busy_reg;
    logic                        done_reg;
    logic [fia_pkg::CNT_W:0]     trial;
    logic [fia_pkg::CNT_W:0]     diff;
    logic                        ge;
    logic [fia_pkg::CNT_W-1:0]   rem_next;

    always_comb begin
        trial    = {rem_reg, dvd_reg[fia_pkg::DVD_W-1]};
        diff     = trial - {1'b0, dsr_reg};
        ge       = (trial >= {1'b0, dsr_reg});
        rem_next = ge ? diff[fia_pkg::CNT_W-1:0] : trial[fia_pkg::CNT_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= fia_pkg::DSTEP_W'(fia_pkg::DVD_W);
            end else if (busy_reg) begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == fia_pkg::DSTEP_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[fia_pkg::DVD_W-2:0], ge};
            rem_reg <= rem_next;
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

// File: hw/rtl/fia_back.sv
`timescale 1ns / 1ps
// Back end: per-category timer state, interval ring and result register.
module fia_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        q_valid,
    input  fia_pkg::cmd_word_t          q_word,
    output logic                        q_pop,
    input  logic [fia_pkg::CFG_W-1:0]   fixed_interval,
    output logic                        div_start,
    output logic [fia_pkg::DVD_W-1:0]   div_dividend,
    output logic [fia_pkg::CNT_W-1:0]   div_divisor,
    input  logic                        div_done,
    input  logic [fia_pkg::DVD_W-1:0]   div_quotient,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [fia_pkg::TICK_W-1:0]  m_delta_ticks,
    output logic [fia_pkg::AVG_W-1:0]   m_average_ticks,
    output logic                        m_step_due,
    output logic [fia_pkg::TICK_W-1:0]  m_elapsed_ticks,
    output fia_pkg::bk_status_t         status
);

    fia_pkg::bk_state_t state_reg, state_next;
    fia_pkg::cmd_word_t work_reg;
    logic [fia_pkg::TICK_W-1:0] delta_reg;

    // Per-category state
    logic [fia_pkg::TICK_W-1:0] start_reg  [fia_pkg::CAT_N];
    logic [fia_pkg::TICK_W-1:0] last_reg   [fia_pkg::CAT_N];
    logic [fia_pkg::POS_W-1:0]  pos_reg    [fia_pkg::CAT_N];
    logic [fia_pkg::CNT_W-1:0]  cnt_reg    [fia_pkg::CAT_N];
    logic [fia_pkg::SUM_W-1:0]  sum_reg    [fia_pkg::CAT_N];
    logic [fia_pkg::ACC_W-1:0]  acc_reg    [fia_pkg::CAT_N];
    logic [fia_pkg::TICK_W-1:0] ldelta_reg [fia_pkg::CAT_N];
    logic [fia_pkg::AVG_W-1:0]  lavg_reg   [fia_pkg::CAT_N];

    // Interval ring; an entry without its valid bit reads as zero
    logic [fia_pkg::TICK_W-1:0] ring_mem [fia_pkg::RING_N];
    logic [fia_pkg::RING_N-1:0] ring_valid_reg;
    logic [fia_pkg::TICK_W-1:0] rd_data_reg;
    logic                       rd_valid_reg;

    logic                        m_valid_reg;
    logic [fia_pkg::TICK_W-1:0]  m_delta_reg;
    logic [fia_pkg::AVG_W-1:0]   m_avg_reg;
    logic                        m_step_reg;
    logic [fia_pkg::TICK_W-1:0]  m_elapsed_reg;

    logic [fia_pkg::CIDX_W-1:0]  cidx;
    logic [fia_pkg::RING_AW-1:0] ring_addr;
    logic [fia_pkg::TICK_W-1:0]  old_val;
    logic [fia_pkg::SUM_W-1:0]   sum_new;
    logic [fia_pkg::ACC_W-1:0]   acc_sub;
    logic [fia_pkg::ACC_W:0]     acc_add;
    logic [fia_pkg::ACC_W-1:0]   acc_new;
    logic [fia_pkg::CNT_W-1:0]   cnt_new;
    logic [fia_pkg::POS_W-1:0]   pos_new;
    logic                        out_free;
    logic                        emit_load;

    assign cidx      = fia_pkg::CIDX_W'(work_reg.cat);
    assign ring_addr = fia_pkg::RING_AW'(int'(cidx) * fia_pkg::FRAMES + int'(pos_reg[cidx]));
    assign out_free  = !m_valid_reg || m_ready;

    // Mark datapath
    always_comb begin
        old_val = rd_valid_reg ? rd_data_reg : '0;
        sum_new = sum_reg[cidx] - fia_pkg::SUM_W'(old_val) + fia_pkg::SUM_W'(delta_reg);
        acc_sub = (acc_reg[cidx] > fia_pkg::ACC_W'(fixed_interval))
                  ? acc_reg[cidx] - fia_pkg::ACC_W'(fixed_interval) : acc_reg[cidx];
        acc_add = {1'b0, acc_sub} + (fia_pkg::ACC_W + 1)'(delta_reg);
        acc_new = acc_add[fia_pkg::ACC_W] ? '1 : acc_add[fia_pkg::ACC_W-1:0];
        cnt_new = (cnt_reg[cidx] < fia_pkg::CNT_W'(fia_pkg::FRAMES))
                  ? cnt_reg[cidx] + 1'b1 : cnt_reg[cidx];
        pos_new = (pos_reg[cidx] == fia_pkg::POS_W'(fia_pkg::FRAMES - 1))
                  ? '0 : pos_reg[cidx] + 1'b1;
    end

    assign div_dividend = {sum_new, {fia_pkg::FRAC_W{1'b0}}};
    assign div_divisor  = cnt_new;

    // Sequencer
    always_comb begin
        state_next = state_reg;
        q_pop      = 1'b0;
        div_start  = 1'b0;
        emit_load  = 1'b0;
        unique case (state_reg)
            fia_pkg::BK_IDLE: begin
                if (q_valid) begin
                    q_pop      = 1'b1;
                    state_next = fia_pkg::BK_DISPATCH;
                end
            end
            fia_pkg::BK_DISPATCH: begin
                state_next = (work_reg.kind == fia_pkg::CMD_MARK)
                             ? fia_pkg::BK_LOAD : fia_pkg::BK_EMIT;
            end
            fia_pkg::BK_LOAD: begin
                div_start  = 1'b1;
                state_next = fia_pkg::BK_DIV;
            end
            fia_pkg::BK_DIV: begin
                if (div_done) begin
                    state_next = fia_pkg::BK_EMIT;
                end
            end
            fia_pkg::BK_EMIT: begin
                if (out_free) begin
                    emit_load  = 1'b1;
                    state_next = fia_pkg::BK_IDLE;
                end
            end
            default: state_next = fia_pkg::BK_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= fia_pkg::BK_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            work_reg <= q_word;
        end
        if (state_reg == fia_pkg::BK_DISPATCH) begin
            delta_reg <= work_reg.now - last_reg[cidx];
        end
    end

    // Category state and ring valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < fia_pkg::CAT_N; c++) begin
                start_reg[c]  <= '0;
                last_reg[c]   <= '0;
                pos_reg[c]    <= '0;
                cnt_reg[c]    <= '0;
                sum_reg[c]    <= '0;
                acc_reg[c]    <= '0;
                ldelta_reg[c] <= '0;
                lavg_reg[c]   <= '0;
            end
            ring_valid_reg <= '0;
        end else begin
            if (state_reg == fia_pkg::BK_DISPATCH) begin
                unique case (work_reg.kind)
                    fia_pkg::CMD_START: begin
                        start_reg[cidx]  <= work_reg.now;
                        last_reg[cidx]   <= work_reg.now;
                        pos_reg[cidx]    <= '0;
                        cnt_reg[cidx]    <= '0;
                        sum_reg[cidx]    <= '0;
                        acc_reg[cidx]    <= '0;
                        ldelta_reg[cidx] <= '0;
                        lavg_reg[cidx]   <= '0;
                        for (int i = 0; i < fia_pkg::FRAMES; i++) begin
                            ring_valid_reg[fia_pkg::RING_AW'(int'(cidx) * fia_pkg::FRAMES + i)]
                                <= 1'b0;
                        end
                    end
                    fia_pkg::CMD_BEGIN: begin
                        last_reg[cidx] <= work_reg.now;
                    end
                    fia_pkg::CMD_MARK: begin
                        last_reg[cidx]   <= work_reg.now;
                        ldelta_reg[cidx] <= work_reg.now - last_reg[cidx];
                    end
                    fia_pkg::CMD_NONE, fia_pkg::CMD_QUERY: begin
                    end
                    default: begin
                    end
                endcase
            end
            if (state_reg == fia_pkg::BK_LOAD) begin
                ring_valid_reg[ring_addr] <= 1'b1;
                sum_reg[cidx]             <= sum_new;
                pos_reg[cidx]             <= pos_new;
                cnt_reg[cidx]             <= cnt_new;
                acc_reg[cidx]             <= acc_new;
            end
            if (state_reg == fia_pkg::BK_DIV && div_done) begin
                lavg_reg[cidx] <= div_quotient[fia_pkg::AVG_W-1:0];
            end
        end
    end

    // Ring memory: read while dispatching a mark, write in the cycle after, in the load state
    always_ff @(posedge aclk) begin
        if (state_reg == fia_pkg::BK_DISPATCH) begin
            rd_data_reg  <= ring_mem[ring_addr];
            rd_valid_reg <= ring_valid_reg[ring_addr];
        end
        if (state_reg == fia_pkg::BK_LOAD) begin
            ring_mem[ring_addr] <= delta_reg;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_load) begin
            if (work_reg.kind == fia_pkg::CMD_NONE) begin
                m_delta_reg   <= '0;
                m_avg_reg     <= '0;
                m_step_reg    <= 1'b0;
                m_elapsed_reg <= '0;
            end else begin
                m_delta_reg   <= ldelta_reg[cidx];
                m_avg_reg     <= lavg_reg[cidx];
                m_step_reg    <= (acc_reg[cidx] >= fia_pkg::ACC_W'(fixed_interval));
                m_elapsed_reg <= work_reg.now - start_reg[cidx];
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_delta_ticks   = m_delta_reg;
    assign m_average_ticks = m_avg_reg;
    assign m_step_due      = m_step_reg;
    assign m_elapsed_ticks = m_elapsed_reg;

    assign status.div_wait = (state_reg == fia_pkg::BK_DIV);
    assign status.emit     = (state_reg == fia_pkg::BK_EMIT);

endmodule

// File: hw/rtl/frame_interval_averager.sv
`timescale 1ns / 1ps
// Top level of the frame interval averager.
//
// Per-category frame timer. Each word on the s_ channel carries an operation
// (start, begin tracking, mark frame end), a category and a free-running tick
// stamp; every accepted word yields exactly one result word on the m_ channel
// with the latest interval, the 8-bit-fraction mean of the recent intervals,
// the fixed-step due flag and the ticks elapsed since the category's start.
// A category out of range returns an all-zero word and changes nothing.
//
// cfg_ channel writes fixed_interval (reset 16667); it is always ready and
// should only be written while no word is in flight.
//
// Flow: start, begin and query words go through dispatch to emit; a mark
// also does the ring read-modify-write and runs the bit-serial mean divider
// (44 quotient bits of the scaled sum, one per cycle). The back end takes one
// word at a time; a two-entry command queue lets the front accept meanwhile.
// Reset: all timers, sums and accumulators go to zero and every ring slot
// reads as zero (per-slot valid bits), so no clearing pass is needed.
// A stalled m_ready holds the result register; the back end then waits and
// the queue fills until s_ready drops.
module frame_interval_averager (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [fia_pkg::CFG_W-1:0]   cfg_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [fia_pkg::FUNC_W-1:0]  s_func,
    input  logic [fia_pkg::CAT_W-1:0]   s_category,
    input  logic [fia_pkg::TICK_W-1:0]  s_now_ticks,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [fia_pkg::TICK_W-1:0]  m_delta_ticks,
    output logic [fia_pkg::AVG_W-1:0]   m_average_ticks,
    output logic                        m_step_due,
    output logic [fia_pkg::TICK_W-1:0]  m_elapsed_ticks
);

    logic [fia_pkg::CFG_W-1:0] fixed_interval_reg;

    logic                       q_valid;
    fia_pkg::cmd_word_t         q_word;
    logic                       q_pop;
    logic                       div_start;
    logic [fia_pkg::DVD_W-1:0]  div_dividend;
    logic [fia_pkg::CNT_W-1:0]  div_divisor;
    logic                       div_busy;
    logic                       div_done;
    logic [fia_pkg::DVD_W-1:0]  div_quotient;
    fia_pkg::bk_status_t        bk_status;

    // Config register
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fixed_interval_reg <= fia_pkg::CFG_RESET;
        end else if (cfg_valid && cfg_ready) begin
            fixed_interval_reg <= cfg_data;
        end
    end

    fia_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_func      (s_func),
        .s_category  (s_category),
        .s_now_ticks (s_now_ticks),
        .q_valid     (q_valid),
        .q_word      (q_word),
        .q_pop       (q_pop)
    );

    fia_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quotient)
    );

    fia_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_valid         (q_valid),
        .q_word          (q_word),
        .q_pop           (q_pop),
        .fixed_interval  (fixed_interval_reg),
        .div_start       (div_start),
        .div_dividend    (div_dividend),
        .div_divisor     (div_divisor),
        .div_done        (div_done),
        .div_quotient    (div_quotient),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_delta_ticks   (m_delta_ticks),
        .m_average_ticks (m_average_ticks),
        .m_step_due      (m_step_due),
        .m_elapsed_ticks (m_elapsed_ticks),
        .status          (bk_status)
    );

    // The divider only runs while the back end waits on it
    a_div_owned: assert property (@(posedge aclk) disable iff (!aresetn)
        div_busy |-> bk_status.div_wait)
        else $error("divider busy outside the divide wait");

    // A finished divide moves straight to result emission
    a_div_to_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (bk_status.div_wait && div_done) |=> bk_status.emit)
        else $error("divide done but no emit");

    // A new result word only appears out of the emit step
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(bk_status.emit))
        else $error("result word raised outside emit");

    // An empty command queue always takes a word
    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !q_valid |-> s_ready)
        else $error("empty queue refused a word");

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the frame interval averager: directed table, then random frame streams.
module testbench;

    // Codes that the package leaves unnamed
    localparam logic [fia_pkg::FUNC_W-1:0] FUNC_QUERY = 2'd3;
    localparam logic [fia_pkg::CAT_W-1:0]  CAT_FRAME  = 2'd0;
    localparam logic [fia_pkg::CAT_W-1:0]  CAT_CPU    = 2'd1;
    localparam logic [fia_pkg::CAT_W-1:0]  CAT_GPU    = 2'd2;
    localparam logic [fia_pkg::CAT_W-1:0]  CAT_UNUSED = 2'd3;

    localparam int IDLE_LIMIT  = 5000;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 100;
    localparam int DIRECTED_N  = 22;

    typedef struct packed {
        logic [fia_pkg::TICK_W-1:0] delta;
        logic [fia_pkg::AVG_W-1:0]  average;
        logic                       step_due;
        logic [fia_pkg::TICK_W-1:0] elapsed;
    } timer_word_t;

    typedef struct packed {
        logic [fia_pkg::FUNC_W-1:0] op;
        logic [fia_pkg::CAT_W-1:0]  cat;
        logic [fia_pkg::TICK_W-1:0] now;
        logic                       typed;
        timer_word_t                want;
    } stim_row_t;

    localparam timer_word_t NO_WORD = '0;

    logic                         aclk        = 1'b0;
    logic                         aresetn     = 1'b0;
    logic                         cfg_valid   = 1'b0;
    logic                         cfg_ready;
    logic [fia_pkg::CFG_W-1:0]    cfg_data    = '0;
    logic                         s_valid     = 1'b0;
    logic                         s_ready;
    logic [fia_pkg::FUNC_W-1:0]   s_func      = '0;
    logic [fia_pkg::CAT_W-1:0]    s_category  = '0;
    logic [fia_pkg::TICK_W-1:0]   s_now_ticks = '0;
    logic                         m_valid;
    logic                         m_ready     = 1'b0;
    logic [fia_pkg::TICK_W-1:0]   m_delta_ticks;
    logic [fia_pkg::AVG_W-1:0]    m_average_ticks;
    logic                         m_step_due;
    logic [fia_pkg::TICK_W-1:0]   m_elapsed_ticks;

    frame_interval_averager dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_func          (s_func),
        .s_category      (s_category),
        .s_now_ticks     (s_now_ticks),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_delta_ticks   (m_delta_ticks),
        .m_average_ticks (m_average_ticks),
        .m_step_due      (m_step_due),
        .m_elapsed_ticks (m_elapsed_ticks)
    );

    always #5 aclk = ~aclk;

    // Timer state as the block should hold it
    logic [fia_pkg::CFG_W-1:0]  step_len = fia_pkg::CFG_RESET;
    logic [fia_pkg::TICK_W-1:0] tmr_start  [fia_pkg::CAT_N] = '{default: '0};
    logic [fia_pkg::TICK_W-1:0] tmr_last   [fia_pkg::CAT_N] = '{default: '0};
    logic [fia_pkg::TICK_W-1:0] interval_hist [fia_pkg::CAT_N][fia_pkg::FRAMES]
                                            = '{default: '{default: '0}};
    logic [fia_pkg::POS_W-1:0]  hist_pos   [fia_pkg::CAT_N] = '{default: '0};
    logic [fia_pkg::CNT_W-1:0]  hist_count [fia_pkg::CAT_N] = '{default: '0};
    logic [fia_pkg::SUM_W-1:0]  hist_sum   [fia_pkg::CAT_N] = '{default: '0};
    logic [fia_pkg::ACC_W-1:0]  step_acc   [fia_pkg::CAT_N] = '{default: '0};
    logic [fia_pkg::TICK_W-1:0] tmr_delta  [fia_pkg::CAT_N] = '{default: '0};
    logic [fia_pkg::AVG_W-1:0]  tmr_avg    [fia_pkg::CAT_N] = '{default: '0};

    // Free-running clock of each well-formed random stream
    logic [fia_pkg::TICK_W-1:0] stream_now [fia_pkg::CAT_N] = '{default: '0};

    timer_word_t pending_words [$];
    int burst_left   = 0;
    int bad_words    = 0;
    int results_seen = 0;
    int quiet_cycles = 0;
    int hold_left    = 0;
    bit hold_done    = 1'b0;
    int mode_left    = 0;
    int ready_mode   = 0;

    function automatic timer_word_t timer_outcome(input logic [fia_pkg::FUNC_W-1:0] op,
                                                  input logic [fia_pkg::CAT_W-1:0] cat,
                                                  input logic [fia_pkg::TICK_W-1:0] now);
        timer_word_t                w;
        logic [fia_pkg::ACC_W-1:0]  acc;
        logic [fia_pkg::ACC_W:0]    acc_next;
        logic [fia_pkg::DVD_W-1:0]  scaled;
        logic [fia_pkg::DVD_W-1:0]  quo;
        logic [fia_pkg::TICK_W-1:0] gap;
        int                         c;
        int                         i;
        w = '0;
        if (cat >= fia_pkg::CAT_N) return w;
        c = cat;
        case (op)
            fia_pkg::FUNC_START: begin
                tmr_start[c] = now;
                tmr_last[c] = now;
                for (i = 0; i < fia_pkg::FRAMES; i++) interval_hist[c][i] = '0;
                hist_pos[c] = '0;
                hist_count[c] = '0;
                hist_sum[c] = '0;
                step_acc[c] = '0;
                tmr_delta[c] = '0;
                tmr_avg[c] = '0;
            end
            fia_pkg::FUNC_BEGIN: tmr_last[c] = now;
            fia_pkg::FUNC_MARK: begin
                gap = now - tmr_last[c];
                tmr_last[c] = now;
                tmr_delta[c] = gap;
                // pay off one step before the new interval is credited
                acc = step_acc[c];
                if (acc > fia_pkg::ACC_W'(step_len)) acc = acc - fia_pkg::ACC_W'(step_len);
                hist_sum[c] = hist_sum[c]
                              - fia_pkg::SUM_W'(interval_hist[c][hist_pos[c]])
                              + fia_pkg::SUM_W'(gap);
                interval_hist[c][hist_pos[c]] = gap;
                hist_pos[c] = hist_pos[c] + 1'b1;
                if (hist_count[c] < fia_pkg::FRAMES) hist_count[c] = hist_count[c] + 1'b1;
                scaled = {hist_sum[c], {fia_pkg::FRAC_W{1'b0}}};
                quo = scaled / fia_pkg::DVD_W'(hist_count[c]);
                tmr_avg[c] = quo[fia_pkg::AVG_W-1:0];
                acc_next = {1'b0, acc} + (fia_pkg::ACC_W + 1)'(gap);
                step_acc[c] = acc_next[fia_pkg::ACC_W] ? '1 : acc_next[fia_pkg::ACC_W-1:0];
            end
            default: ;  // unused code reads back only
        endcase
        w.delta = tmr_delta[c];
        w.average = tmr_avg[c];
        w.step_due = (step_acc[c] >= fia_pkg::ACC_W'(step_len));
        w.elapsed = now - tmr_start[c];
        return w;
    endfunction

    // Offer one word; the sender runs in bursts with gaps between them
    task automatic send_word(input logic [fia_pkg::FUNC_W-1:0] op,
                             input logic [fia_pkg::CAT_W-1:0] cat,
                             input logic [fia_pkg::TICK_W-1:0] now, input logic typed,
                             input timer_word_t want);
        timer_word_t got;
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 24)) @(negedge aclk);
            burst_left = $urandom_range(1, 48);
        end
        s_valid <= 1'b1;
        s_func <= op;
        s_category <= cat;
        s_now_ticks <= now;
        do @(posedge aclk); while (s_ready !== 1'b1);
        got = timer_outcome(op, cat, now);
        pending_words.push_back(typed ? want : got);
        burst_left--;
        @(negedge aclk);
    endtask

    // Mostly well-formed per-category streams, some noise
    task automatic send_random(input int count);
        int                         n;
        int                         r;
        int                         s;
        int                         c;
        logic [fia_pkg::TICK_W-1:0] step;
        logic [fia_pkg::FUNC_W-1:0] op;
        for (n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            s = $urandom_range(0, 99);
            c = $urandom_range(0, fia_pkg::CAT_N - 1);
            if (s < 55) step = step_len + fia_pkg::TICK_W'($urandom_range(0, 64)) - 32'd32;
            else if (s < 85) step = $urandom_range(0, 3000);
            else step = $urandom;
            if (r < 4) begin
                send_word(fia_pkg::FUNC_W'($urandom_range(0, 3)),
                          fia_pkg::CAT_W'($urandom_range(0, 3)),
                          $urandom, 1'b0, NO_WORD);
            end else if (r < 7) begin
                send_word(fia_pkg::FUNC_W'($urandom_range(0, 3)), CAT_UNUSED, $urandom,
                          1'b0, NO_WORD);
            end else begin
                stream_now[c] = stream_now[c] + step;
                if (r < 11) op = FUNC_QUERY;
                else if (r < 16) op = fia_pkg::FUNC_START;
                else if (r < 26) op = fia_pkg::FUNC_BEGIN;
                else op = fia_pkg::FUNC_MARK;
                send_word(op, fia_pkg::CAT_W'(c), stream_now[c], 1'b0, NO_WORD);
            end
        end
    endtask

    // Stop offering and wait for every outstanding result
    task automatic drain();
        s_valid <= 1'b0;
        burst_left = 0;
        @(negedge aclk);
        while (pending_words.size() != 0) @(negedge aclk);
    endtask

    task automatic write_step_len(input logic [fia_pkg::CFG_W-1:0] len);
        cfg_valid <= 1'b1;
        cfg_data <= len;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        step_len = len;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // typed rows: results readable straight off the spec
    stim_row_t plan [DIRECTED_N] = '{
        '{fia_pkg::FUNC_BEGIN, CAT_FRAME,  32'h0000_1234, 1'b1,
          '{32'd0, 40'd0, 1'b0, 32'h0000_1234}},
        '{FUNC_QUERY,          CAT_CPU,    32'hFFFF_FFFF, 1'b1,
          '{32'd0, 40'd0, 1'b0, 32'hFFFF_FFFF}},
        '{fia_pkg::FUNC_MARK,  CAT_UNUSED, 32'hDEAD_BEEF, 1'b1, NO_WORD},
        '{fia_pkg::FUNC_START, CAT_UNUSED, 32'h0000_0000, 1'b1, NO_WORD},
        '{fia_pkg::FUNC_START, CAT_FRAME,  32'd100,       1'b1, NO_WORD},
        '{fia_pkg::FUNC_MARK,  CAT_FRAME,  32'd16767,     1'b1,
          '{32'd16667, 40'd4266752, 1'b1, 32'd16667}},
        '{fia_pkg::FUNC_MARK,  CAT_FRAME,  32'd33435,     1'b0, NO_WORD},
        '{fia_pkg::FUNC_MARK,  CAT_FRAME,  32'd33435,     1'b0, NO_WORD},
        '{fia_pkg::FUNC_BEGIN, CAT_FRAME,  32'd40000,     1'b0, NO_WORD},
        '{fia_pkg::FUNC_MARK,  CAT_FRAME,  32'd40010,     1'b0, NO_WORD},
        '{fia_pkg::FUNC_START, CAT_CPU,    32'hFFFF_FFF0, 1'b0, NO_WORD},
        '{fia_pkg::FUNC_MARK,  CAT_CPU,    32'h0000_0010, 1'b0, NO_WORD},
        '{fia_pkg::FUNC_BEGIN, CAT_CPU,    32'h0000_0100, 1'b0, NO_WORD},
        '{fia_pkg::FUNC_MARK,  CAT_CPU,    32'h0000_0180, 1'b0, NO_WORD},
        '{FUNC_QUERY,          CAT_CPU,    32'h0000_0200, 1'b0, NO_WORD},
        '{fia_pkg::FUNC_MARK,  CAT_GPU,    32'hFFFF_FFFF, 1'b0, NO_WORD},
        '{fia_pkg::FUNC_MARK,  CAT_GPU,    32'hFFFF_FFFE, 1'b0, NO_WORD},
        '{fia_pkg::FUNC_BEGIN, CAT_UNUSED, 32'd5,         1'b1, NO_WORD},
        '{fia_pkg::FUNC_START, CAT_GPU,    32'h8000_0000, 1'b0, NO_WORD},
        '{FUNC_QUERY,          CAT_GPU,    32'h8000_0001, 1'b0, NO_WORD},
        '{fia_pkg::FUNC_MARK,  CAT_GPU,    32'h8000_4123, 1'b0, NO_WORD},
        '{FUNC_QUERY,          CAT_FRAME,  32'h0000_0000, 1'b0, NO_WORD}
    };

    initial begin : stimulus
        int                         k;
        logic [fia_pkg::TICK_W-1:0] sat_now;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (k = 0; k < DIRECTED_N; k++)
            send_word(plan[k].op, plan[k].cat, plan[k].now, plan[k].typed, plan[k].want);
        send_random(300);
        drain();

        // shortest step: max-length intervals drive the accumulator into saturation
        write_step_len(32'd1);
        send_word(fia_pkg::FUNC_START, CAT_FRAME, '0, 1'b0, NO_WORD);
        sat_now = '1;
        for (k = 0; k < 300; k++) begin
            send_word(fia_pkg::FUNC_MARK, CAT_FRAME, sat_now, 1'b0, NO_WORD);
            sat_now = sat_now - 1'b1;
        end
        send_random(200);
        drain();

        write_step_len(32'hFFFF_FFFF);
        send_random(250);
        drain();

        // zero step: flag always set, nothing paid off
        write_step_len(32'd0);
        send_random(150);
        drain();

        write_step_len(fia_pkg::CFG_W'($urandom_range(2, 200000)));
        send_random(300);
        drain();

        write_step_len(fia_pkg::CFG_RESET);
        send_random(200);
        drain();

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (bad_words == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end

    // Receiver: one long hold-off once traffic is going, else a changing stall pattern
    always @(negedge aclk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else if (!hold_done && results_seen >= 150) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
            m_ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                ready_mode <= $urandom_range(0, 2);
                mode_left <= $urandom_range(50, 300);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (ready_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= $urandom_range(0, 1);
                default: m_ready <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    always @(posedge aclk) begin : check_results
        timer_word_t seen;
        timer_word_t want;
        if (aresetn && m_valid && m_ready) begin
            seen = '{m_delta_ticks, m_average_ticks, m_step_due, m_elapsed_ticks};
            results_seen = results_seen + 1;
            if (pending_words.size() == 0) begin
                if (bad_words < 10)
                    $display("unexpected word: delta %h avg %h due %b elapsed %h",
                             seen.delta, seen.average, seen.step_due, seen.elapsed);
                bad_words = bad_words + 1;
            end else begin
                want = pending_words.pop_front();
                if (seen !== want) begin
                    if (bad_words < 10)
                        $display("mismatch: delta %h/%h avg %h/%h due %b/%b elapsed %h/%h (exp/got)",
                                 want.delta, seen.delta, want.average, seen.average,
                                 want.step_due, seen.step_due, want.elapsed, seen.elapsed);
                    bad_words = bad_words + 1;
                end
            end
        end
    end

    // Watchdog: too long with no handshake on any channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
